### hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
		else $error("assertion failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
		else $error("assertion failed");

`endif

### hw/rtl/mfap_pkg.sv
`timescale 1ns / 1ps
package mfap_pkg;
	localparam int MAX_NODES = 64;
	localparam int NODE_W = $clog2(MAX_NODES);
	localparam int NCNT_W = NODE_W + 1;
	localparam int CAP_BITS = 16;
	localparam int ADDR_W = 2 * NODE_W;
	localparam int MAT_DEPTH = MAX_NODES * MAX_NODES;
	localparam int TOTAL_W = 22;
	localparam int COUNT_W = 16;
	localparam int ACC_W = TOTAL_W + 1;

	localparam logic [CAP_BITS-1:0] CAP_MASK = '1;
	localparam logic [ACC_W-1:0] TOTAL_MAX = ACC_W'(4194303);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	localparam logic [1:0] MODE_WRITE = 2'd0;
	localparam logic [1:0] MODE_RUN = 2'd1;
	localparam logic [1:0] MODE_CLEAR = 2'd2;

	typedef struct packed {
		logic [1:0] mode;
		logic [5:0] from_node;
		logic [5:0] to_node;
		logic [15:0] capacity;
	} cmd_t;

	typedef struct packed {
		logic [21:0] total_flow;
		logic [15:0] path_count;
	} res_t;

	// per-node label record
	typedef struct packed {
		logic [NODE_W-1:0] pred;
		logic back;
		logic [CAP_BITS-1:0] bn;
	} node_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [TOTAL_W-1:0] total_flow;
		logic [COUNT_W-1:0] path_count;
	} eng_rsp_t;
endpackage

### hw/rtl/mfap_ram.sv
`timescale 1ns / 1ps
module mfap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	localparam int AW = $clog2(DEPTH)
) (
	input logic clk,
	input logic we,
	input logic [AW-1:0] waddr,
	input logic [WIDTH-1:0] wdata,
	input logic [AW-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### hw/rtl/mfap_engine.sv
`timescale 1ns / 1ps
module mfap_engine (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic [mfap_pkg::NCNT_W-1:0] node_count,
	output logic [mfap_pkg::ADDR_W-1:0] cap_raddr,
	input logic [mfap_pkg::CAP_BITS-1:0] cap_rdata,
	output mfap_pkg::eng_rsp_t rsp
);
	import mfap_pkg::*;

	localparam logic [3:0] E_IDLE = 4'd0;
	localparam logic [3:0] E_FCLR = 4'd1;
	localparam logic [3:0] E_SCAN = 4'd2;
	localparam logic [3:0] E_DRAIN = 4'd3;
	localparam logic [3:0] E_SINK = 4'd4;
	localparam logic [3:0] E_PRD = 4'd5;
	localparam logic [3:0] E_FWR = 4'd6;
	localparam logic [3:0] E_NEXT = 4'd7;
	localparam logic [3:0] E_QRD = 4'd8;
	localparam logic [3:0] E_BHRD = 4'd9;
	localparam logic [3:0] E_SUM = 4'd10;
	localparam logic [3:0] E_SUMW = 4'd11;
	localparam logic [3:0] E_DONE = 4'd12;

	logic [3:0] state_q;
	logic [ADDR_W-1:0] cnt_q;
	logic [NODE_W-1:0] h_q, j_q, v_q;
	logic dir_q, first_q, back_q;
	logic [CAP_BITS-1:0] bh_q, b_q;
	logic [ADDR_W-1:0] faddr_q;
	logic [NCNT_W-1:0] head_q, tail_q;
	logic [MAX_NODES-1:0] lab_q;
	logic [COUNT_W-1:0] paths_q;
	logic [ACC_W-1:0] acc_q;
	logic valid_s1, dir_s1, sum_s1;
	logic [NODE_W-1:0] j_s1;

	logic [NCNT_W-1:0] n_w;
	logic [NODE_W-1:0] sink_w;
	logic [ADDR_W-1:0] scan_addr, path_addr;
	logic flow_we;
	logic [ADDR_W-1:0] flow_waddr, flow_raddr;
	logic [CAP_BITS-1:0] flow_wdata, flow_rdata;
	logic node_we;
	logic [NODE_W-1:0] node_raddr;
	node_t node_wdata, node_rdata;
	logic q_we;
	logic [NODE_W-1:0] q_rdata;
	logic fwd_ok, back_ok, lab_hit;
	logic [CAP_BITS-1:0] amt, amount;

	// node count clamped to the legal range
	always_comb begin
		if (node_count < NCNT_W'(2)) begin
			n_w = NCNT_W'(2);
		end else if (node_count > NCNT_W'(MAX_NODES)) begin
			n_w = NCNT_W'(MAX_NODES);
		end else begin
			n_w = node_count;
		end
	end
	assign sink_w = NODE_W'(n_w - NCNT_W'(1));

	// matrix addresses for the scan and the path walk
	assign scan_addr = dir_q ? {j_q, h_q} : {h_q, j_q};
	assign path_addr = node_rdata.back ? {v_q, node_rdata.pred} : {node_rdata.pred, v_q};
	assign cap_raddr = scan_addr;

	always_comb begin
		case (state_q)
			E_PRD: flow_raddr = path_addr;
			E_SUM: flow_raddr = {NODE_W'(0), j_q};
			default: flow_raddr = scan_addr;
		endcase
	end

	always_comb begin
		case (state_q)
			E_FWR: node_raddr = v_q;
			E_QRD: node_raddr = q_rdata;
			default: node_raddr = sink_w;
		endcase
	end

	// labelling decision on the words read in the previous cycle
	assign lab_hit = lab_q[j_s1];
	assign fwd_ok = (cap_rdata != '0) && !lab_hit && (cap_rdata > flow_rdata);
	assign back_ok = (cap_rdata != '0) && !lab_hit && (flow_rdata != '0);
	assign amt = dir_s1 ? flow_rdata : (cap_rdata - flow_rdata);
	assign amount = (amt < bh_q) ? amt : bh_q;
	assign node_we = valid_s1 && (dir_s1 ? back_ok : fwd_ok);
	assign q_we = node_we && (tail_q != NCNT_W'(MAX_NODES));
	assign node_wdata = '{pred: h_q, back: dir_s1, bn: amount};

	// flow store write: clearing sweep or path update
	always_comb begin
		flow_we = 1'b0;
		flow_waddr = faddr_q;
		flow_wdata = back_q ? (flow_rdata - b_q) : (flow_rdata + b_q);
		case (state_q)
			E_FCLR: begin
				flow_we = 1'b1;
				flow_waddr = cnt_q;
				flow_wdata = '0;
			end
			E_FWR: flow_we = 1'b1;
			default: flow_we = 1'b0;
		endcase
	end

	mfap_ram #(.WIDTH(CAP_BITS), .DEPTH(MAT_DEPTH)) u_flow (
		.clk(clk), .we(flow_we), .waddr(flow_waddr), .wdata(flow_wdata),
		.raddr(flow_raddr), .rdata(flow_rdata)
	);

	mfap_ram #(.WIDTH($bits(node_t)), .DEPTH(MAX_NODES)) u_node (
		.clk(clk), .we(node_we), .waddr(j_s1), .wdata(node_wdata),
		.raddr(node_raddr), .rdata(node_rdata)
	);

	mfap_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_queue (
		.clk(clk), .we(q_we), .waddr(tail_q[NODE_W-1:0]), .wdata(j_s1),
		.raddr(head_q[NODE_W-1:0]), .rdata(q_rdata)
	);

	// scan pipeline stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			sum_s1 <= 1'b0;
		end else begin
			valid_s1 <= (state_q == E_SCAN);
			sum_s1 <= (state_q == E_SUM);
		end
	end

	always_ff @(posedge clk) begin
		j_s1 <= j_q;
		dir_s1 <= dir_q;
	end

	// run sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= E_IDLE;
			cnt_q <= '0;
			h_q <= '0;
			j_q <= '0;
			v_q <= '0;
			dir_q <= 1'b0;
			first_q <= 1'b0;
			back_q <= 1'b0;
			bh_q <= '0;
			b_q <= '0;
			faddr_q <= '0;
			head_q <= '0;
			tail_q <= '0;
			lab_q <= '0;
			paths_q <= '0;
			acc_q <= '0;
		end else begin
			if (node_we) begin
				lab_q[j_s1] <= 1'b1;
			end
			if (q_we) begin
				tail_q <= tail_q + NCNT_W'(1);
			end
			if (sum_s1) begin
				acc_q <= acc_q + ACC_W'(flow_rdata);
			end
			case (state_q)
				E_IDLE: begin
					if (start) begin
						cnt_q <= '0;
						paths_q <= '0;
						state_q <= E_FCLR;
					end
				end
				E_FCLR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == ADDR_W'(MAT_DEPTH - 1)) begin
						lab_q <= MAX_NODES'(1);
						head_q <= NCNT_W'(1);
						tail_q <= NCNT_W'(1);
						h_q <= '0;
						bh_q <= CAP_MASK;
						j_q <= '0;
						dir_q <= 1'b0;
						state_q <= E_SCAN;
					end
				end
				E_SCAN: begin
					if (j_q == sink_w) begin
						j_q <= '0;
						if (dir_q) begin
							state_q <= E_DRAIN;
						end else begin
							dir_q <= 1'b1;
						end
					end else begin
						j_q <= j_q + NODE_W'(1);
					end
				end
				E_DRAIN: begin
					state_q <= E_SINK;
				end
				E_SINK: begin
					if (lab_q[sink_w]) begin
						v_q <= sink_w;
						first_q <= 1'b1;
						state_q <= E_PRD;
					end else begin
						state_q <= E_NEXT;
					end
				end
				E_PRD: begin
					if (first_q) begin
						b_q <= node_rdata.bn;
					end
					first_q <= 1'b0;
					faddr_q <= path_addr;
					back_q <= node_rdata.back;
					v_q <= node_rdata.pred;
					state_q <= E_FWR;
				end
				E_FWR: begin
					if (v_q == '0) begin
						if (paths_q != COUNT_MAX) begin
							paths_q <= paths_q + COUNT_W'(1);
						end
						lab_q <= MAX_NODES'(1);
						head_q <= NCNT_W'(1);
						tail_q <= NCNT_W'(1);
						h_q <= '0;
						bh_q <= CAP_MASK;
						j_q <= '0;
						dir_q <= 1'b0;
						state_q <= E_SCAN;
					end else begin
						state_q <= E_PRD;
					end
				end
				E_NEXT: begin
					if (head_q < tail_q) begin
						state_q <= E_QRD;
					end else begin
						j_q <= '0;
						acc_q <= '0;
						state_q <= E_SUM;
					end
				end
				E_QRD: begin
					h_q <= q_rdata;
					head_q <= head_q + NCNT_W'(1);
					state_q <= E_BHRD;
				end
				E_BHRD: begin
					bh_q <= node_rdata.bn;
					j_q <= '0;
					dir_q <= 1'b0;
					state_q <= E_SCAN;
				end
				E_SUM: begin
					if (j_q == sink_w) begin
						state_q <= E_SUMW;
					end else begin
						j_q <= j_q + NODE_W'(1);
					end
				end
				E_SUMW: begin
					state_q <= E_DONE;
				end
				E_DONE: begin
					state_q <= E_IDLE;
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	// result towards the output register
	always_comb begin
		rsp.busy = (state_q != E_IDLE);
		rsp.done = (state_q == E_DONE);
		rsp.total_flow = (acc_q > TOTAL_MAX) ? TOTAL_W'(TOTAL_MAX) : TOTAL_W'(acc_q);
		rsp.path_count = paths_q;
	end
endmodule

### hw/rtl/max_flow_augmenting_path_core.sv
// capacity write: one word per cycle while cmd_stall is low, no result
// clear: pass over all 4096 capacity words, also run once after reset; no word is taken then
// run: flow clear over all 4096 words, then per dequeued node a queue read, bottleneck read,
// forward and backward matrix scan over the single-read-port memories, drain, sink test;
// per path edge a predecessor read and flow write; final sum, then the result word is registered
// reset: asynchronous active low; node count 64, capacity pass starts straight after reset
`timescale 1ns / 1ps
`include "assert_macros.svh"
module max_flow_augmenting_path_core (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [6:0] cfg_data,
	input logic cmd_valid,
	output logic cmd_stall,
	input mfap_pkg::cmd_t cmd,
	output logic res_valid,
	input logic res_stall,
	output mfap_pkg::res_t res
);
	import mfap_pkg::*;

	logic [NCNT_W-1:0] node_count_q;
	logic clr_q;
	logic [ADDR_W-1:0] clr_cnt_q;
	logic res_valid_q;
	res_t res_q;
	eng_rsp_t rsp;
	logic accept;
	logic start;
	logic cap_we;
	logic [ADDR_W-1:0] cap_waddr, cap_raddr;
	logic [CAP_BITS-1:0] cap_wdata, cap_rdata;

	// input handshake
	assign cmd_stall = clr_q || rsp.busy || (res_valid_q && (cmd.mode == MODE_RUN));
	assign accept = cmd_valid && !cmd_stall;
	assign start = accept && (cmd.mode == MODE_RUN);

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NCNT_W'(MAX_NODES);
		end else if (cfg_we) begin
			node_count_q <= cfg_data;
		end
	end

	// capacity clearing pass
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end else if (clr_q) begin
			clr_cnt_q <= clr_cnt_q + ADDR_W'(1);
			if (clr_cnt_q == ADDR_W'(MAT_DEPTH - 1)) begin
				clr_q <= 1'b0;
			end
		end else if (accept && (cmd.mode == MODE_CLEAR)) begin
			clr_q <= 1'b1;
			clr_cnt_q <= '0;
		end
	end

	// capacity store write port
	always_comb begin
		if (clr_q) begin
			cap_we = 1'b1;
			cap_waddr = clr_cnt_q;
			cap_wdata = '0;
		end else begin
			cap_we = accept && (cmd.mode == MODE_WRITE);
			cap_waddr = {cmd.from_node, cmd.to_node};
			cap_wdata = cmd.capacity & CAP_MASK;
		end
	end

	mfap_ram #(.WIDTH(CAP_BITS), .DEPTH(MAT_DEPTH)) u_cap (
		.clk(clk), .we(cap_we), .waddr(cap_waddr), .wdata(cap_wdata),
		.raddr(cap_raddr), .rdata(cap_rdata)
	);

	mfap_engine u_engine (
		.clk(clk), .arst_n(arst_n), .start(start), .node_count(node_count_q),
		.cap_raddr(cap_raddr), .cap_rdata(cap_rdata), .rsp(rsp)
	);

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (rsp.done) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rsp.done) begin
			res_q <= '{total_flow: rsp.total_flow, path_count: rsp.path_count};
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

	`ASSERT_IMPL(a_no_take_in_clear, clk, arst_n, clr_q, !accept)
	`ASSERT_IMPL(a_done_into_free_reg, clk, arst_n, rsp.done, !res_valid_q)
	`ASSERT_NEXT(a_run_starts, clk, arst_n, start, rsp.busy)
endmodule

### verif/max_flow_checker.sv
`timescale 1ns / 1ps
module max_flow_checker (
	input logic clk,
	input logic arst_n,
	input logic cfg_we,
	input logic [6:0] cfg_data,
	input logic cmd_valid,
	input logic cmd_stall,
	input mfap_pkg::cmd_t cmd,
	input logic res_valid,
	input logic res_stall,
	input mfap_pkg::res_t res,
	output int errors,
	output int pending,
	output int checked
);
	import mfap_pkg::*;

	logic [6:0] node_reg;
	logic [CAP_BITS-1:0] cap_mem [MAX_NODES][MAX_NODES];
	int unsigned flow_mem [MAX_NODES][MAX_NODES];
	res_t flow_expected [$];

	task automatic report_mismatch(input string msg);
		$display("mismatch at %0t: %s", $realtime, msg);
		errors++;
	endtask

	// edmonds-karp over the stored matrix
	function automatic res_t predict_flow();
		int n, sink, head, tail, h, j, v, p, steps;
		int unsigned paths, total, c, f, bh, amt;
		bit restart;
		int pred [MAX_NODES];
		bit lab [MAX_NODES];
		bit back [MAX_NODES];
		int unsigned bn [MAX_NODES];
		int q [MAX_NODES];
		res_t r;
		n = node_reg;
		if (n < 2) n = 2;
		if (n > MAX_NODES) n = MAX_NODES;
		sink = n - 1;
		paths = 0;
		total = 0;
		head = 0;
		tail = 0;
		for (int a = 0; a < MAX_NODES; a++)
			for (int b = 0; b < MAX_NODES; b++)
				flow_mem[a][b] = 0;
		restart = 1;
		while (1) begin
			if (restart) begin
				for (int i = 0; i < n; i++) begin
					lab[i] = 0;
					back[i] = 0;
					pred[i] = 0;
				end
				lab[0] = 1;
				bn[0] = CAP_MASK;
				head = 0;
				tail = 1;
				q[0] = 0;
				restart = 0;
			end
			if (head >= tail) break;
			h = q[head];
			head++;
			bh = bn[h];
			// forward edges with spare capacity
			for (j = 0; j < n; j++) begin
				c = cap_mem[h][j];
				f = flow_mem[h][j];
				if (c == 0 || lab[j] || c <= f) continue;
				amt = (c - f) < bh ? (c - f) : bh;
				lab[j] = 1; pred[j] = h; back[j] = 0; bn[j] = amt;
				if (tail < MAX_NODES) begin q[tail] = j; tail++; end
			end
			// backward edges carrying flow
			for (j = 0; j < n; j++) begin
				f = flow_mem[j][h];
				if (cap_mem[j][h] == 0 || lab[j] || f == 0) continue;
				amt = f < bh ? f : bh;
				lab[j] = 1; pred[j] = h; back[j] = 1; bn[j] = amt;
				if (tail < MAX_NODES) begin q[tail] = j; tail++; end
			end
			// augment along the path to the sink
			if (lab[sink]) begin
				amt = bn[sink];
				v = sink;
				steps = 0;
				while (v != 0 && steps < n) begin
					p = pred[v] % MAX_NODES;
					if (back[v]) flow_mem[v][p] -= amt;
					else flow_mem[p][v] += amt;
					v = p;
					steps++;
				end
				if (paths < COUNT_MAX) paths++;
				restart = 1;
			end
		end
		for (int i = 0; i < n; i++) total += flow_mem[0][i];
		if (total > TOTAL_MAX) total = TOTAL_MAX;
		r.total_flow = total[TOTAL_W-1:0];
		r.path_count = paths[COUNT_W-1:0];
		return r;
	endfunction

	assign pending = flow_expected.size();

	// track config and commands, compare results
	always @(posedge clk or negedge arst_n) begin
		res_t e;
		if (!arst_n) begin
			node_reg <= 7'd64;
			for (int a = 0; a < MAX_NODES; a++)
				for (int b = 0; b < MAX_NODES; b++)
					cap_mem[a][b] = '0;
			flow_expected.delete();
		end else begin
			if (cfg_we) node_reg <= cfg_data;
			if (cmd_valid && !cmd_stall) begin
				case (cmd.mode)
					MODE_WRITE: cap_mem[cmd.from_node][cmd.to_node] = cmd.capacity & CAP_MASK;
					MODE_RUN: flow_expected.push_back(predict_flow());
					MODE_CLEAR: begin
						for (int a = 0; a < MAX_NODES; a++)
							for (int b = 0; b < MAX_NODES; b++)
								cap_mem[a][b] = '0;
					end
					default: ;
				endcase
			end
			if (res_valid && !res_stall) begin
				if (flow_expected.size() == 0) begin
					report_mismatch("result word with nothing expected");
				end else begin
					e = flow_expected.pop_front();
					checked++;
					if (res.total_flow !== e.total_flow)
						report_mismatch($sformatf("total_flow %0d, expected %0d",
							res.total_flow, e.total_flow));
					if (res.path_count !== e.path_count)
						report_mismatch($sformatf("path_count %0d, expected %0d",
							res.path_count, e.path_count));
				end
			end
		end
	end

	initial begin
		errors = 0;
		checked = 0;
	end
endmodule

### verif/tb_max_flow_augmenting_path_core.sv
`timescale 1ns / 1ps
module tb_max_flow_augmenting_path_core;
	import mfap_pkg::*;

	localparam logic [1:0] MODE_SPARE = 2'd3;
	localparam int IDLE_LIMIT = 600000;
	localparam int SETTLE_CYCLES = 4300;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [6:0] cfg_data;
	logic cmd_valid;
	logic cmd_stall;
	cmd_t cmd;
	logic res_valid;
	logic res_stall;
	res_t res;

	int errors, pending, checked;
	int idle_pct, stall_pct;
	int words_sent, idle_count, phases;

	max_flow_augmenting_path_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res)
	);

	max_flow_checker chk (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_data(cfg_data),
		.cmd_valid(cmd_valid), .cmd_stall(cmd_stall), .cmd(cmd),
		.res_valid(res_valid), .res_stall(res_stall), .res(res),
		.errors(errors), .pending(pending), .checked(checked)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// receiver back-pressure
	always @(negedge clk) begin
		res_stall <= ($urandom_range(99) < stall_pct);
	end

	// watchdog on cycles with no word moving
	always @(posedge clk) begin
		if ((cmd_valid && !cmd_stall) || (res_valid && !res_stall)) idle_count <= 0;
		else idle_count <= idle_count + 1;
		if (idle_count >= IDLE_LIMIT) begin
			$display("watchdog expired with %0d results outstanding", pending);
			$display("FAILED: results differ");
			$finish;
		end
	end

	// one command word, holding valid until taken
	task automatic send_word(input logic [1:0] m, input int f, input int t, input int c);
		while ($urandom_range(99) < idle_pct) begin
			cmd_valid <= 1'b0;
			@(negedge clk);
		end
		cmd_valid <= 1'b1;
		cmd.mode <= m;
		cmd.from_node <= f[5:0];
		cmd.to_node <= t[5:0];
		cmd.capacity <= c[15:0];
		do @(posedge clk); while (cmd_stall);
		words_sent++;
		@(negedge clk);
	endtask

	// drain results, let a clearing pass finish, then write node count
	task automatic set_nodes(input int v);
		cmd_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_data <= v[6:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		phases++;
	endtask

	function automatic int rand_cap();
		case ($urandom_range(9))
			0: return 0;
			1: return 65535;
			2, 3, 4, 5: return $urandom_range(1, 20);
			default: return $urandom_range(65535);
		endcase
	endfunction

	// bias towards source and sink so paths form
	function automatic int pick_node(input int n);
		case ($urandom_range(9))
			0, 1, 2: return 0;
			3, 4, 5: return n - 1;
			default: return $urandom_range(n - 1);
		endcase
	endfunction

	task automatic random_phase(input int cfg, input int budget);
		int n, sent, k, r;
		n = cfg < 2 ? 2 : (cfg > MAX_NODES ? MAX_NODES : cfg);
		set_nodes(cfg);
		idle_pct = (phases % 4 == 1 || phases % 4 == 3) ? (phases % 4 == 1 ? 58 : 25) : 0;
		stall_pct = (phases % 4 == 2) ? 58 : (phases % 4 == 3 ? 25 : 0);
		send_word(MODE_CLEAR, $urandom_range(63), $urandom_range(63), $urandom_range(65535));
		sent = 1;
		while (sent < budget) begin
			k = n > 16 ? $urandom_range(2, 6) : $urandom_range(2, 12);
			repeat (k) begin
				r = $urandom_range(19);
				if (r == 0)
					send_word(MODE_SPARE, $urandom_range(63), $urandom_range(63),
						$urandom_range(65535));
				else if (r == 1)
					send_word(MODE_WRITE, $urandom_range(63), $urandom_range(63), rand_cap());
				else if (r == 2)
					send_word(MODE_WRITE, $urandom_range(n - 1), 0, rand_cap());
				else
					send_word(MODE_WRITE, pick_node(n), pick_node(n), rand_cap());
				sent++;
			end
			send_word(MODE_RUN, $urandom_range(63), $urandom_range(63), $urandom_range(65535));
			sent++;
			// keep big graphs sparse, occasional clear on small ones
			if (n > 16 || $urandom_range(9) == 0) begin
				send_word(MODE_CLEAR, 0, 0, 0);
				sent++;
			end
		end
	endtask

	initial begin
		int cfgs [12] = '{0, 127, 2, 5, 9, 1, 16, 3, 64, 7, 12, 100};
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_data = '0;
		cmd_valid = 1'b0;
		cmd = '0;
		res_stall = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		words_sent = 0;
		idle_count = 0;
		phases = 0;
		repeat (4) @(negedge clk);
		arst_n = 1'b1;

		// directed: default node count, extremes and odd cases
		send_word(MODE_RUN, 0, 0, 0);
		send_word(MODE_WRITE, 0, 63, 65535);
		send_word(MODE_RUN, 63, 63, 65535);
		send_word(MODE_WRITE, 0, 0, 65535);
		send_word(MODE_WRITE, 63, 0, 12);
		send_word(MODE_WRITE, 0, 5, 1);
		send_word(MODE_WRITE, 5, 63, 3);
		send_word(MODE_SPARE, 63, 63, 65535);
		send_word(MODE_RUN, 0, 0, 0);
		send_word(MODE_CLEAR, 63, 63, 65535);
		send_word(MODE_RUN, 0, 0, 0);
		// two nodes, including a backward edge and a self loop on the sink
		set_nodes(2);
		send_word(MODE_WRITE, 0, 1, 40000);
		send_word(MODE_WRITE, 1, 0, 7);
		send_word(MODE_WRITE, 1, 1, 9);
		send_word(MODE_WRITE, 0, 40, 500);
		send_word(MODE_RUN, 0, 0, 0);
		send_word(MODE_WRITE, 0, 1, 0);
		send_word(MODE_RUN, 0, 0, 0);
		// two paths with a crossing edge between the branches
		set_nodes(4);
		send_word(MODE_WRITE, 0, 1, 1);
		send_word(MODE_WRITE, 0, 2, 1);
		send_word(MODE_WRITE, 1, 2, 1);
		send_word(MODE_WRITE, 1, 3, 1);
		send_word(MODE_WRITE, 2, 3, 1);
		send_word(MODE_RUN, 0, 0, 0);

		foreach (cfgs[i])
			random_phase(cfgs[i], (cfgs[i] > 16 && cfgs[i] != 127) ? 40 :
				(cfgs[i] == 127 ? 30 : 115));

		cmd_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
		$display("sent %0d command words over %0d node-count settings", words_sent, phases);
		$display("checked %0d flow results under mixed idle and back-pressure", checked);
		if (errors == 0 && pending == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/mfap_pkg.sv
hw/rtl/mfap_ram.sv
hw/rtl/mfap_engine.sv
hw/rtl/max_flow_augmenting_path_core.sv
verif/max_flow_checker.sv
verif/tb_max_flow_augmenting_path_core.sv
